// ===== hdl/psv_pkg.sv =====
// Package for the sample playback voice: sizes, item function codes,
// configuration register indexes and the sequencer state type.
// No dependencies.
`default_nettype none

package psv_pkg;

    localparam int MEMORY_DEPTH  = 65536;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 16;
    localparam int ADDR_BITS     = $clog2(MEMORY_DEPTH);
    localparam int POS_BITS      = ADDR_BITS + FRACTION_BITS;
    localparam int GAIN_BITS     = 16;
    localparam int GAIN_SHIFT    = SAMPLE_BITS - 1;
    localparam int INC_BITS      = 24;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int OUT_BITS      = 16;

    localparam logic [1:0] FUNC_TICK     = 2'd0;
    localparam logic [1:0] FUNC_NOTE_ON  = 2'd1;
    localparam logic [1:0] FUNC_NOTE_OFF = 2'd2;
    localparam logic [1:0] FUNC_WRITE    = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOOP = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ_B,
        ST_READ_C,
        ST_INTERP,
        ST_SCALE,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/pcm_sample_playback_voice.sv =====
// Top level of the sample playback voice: sequencer, shared multiplier,
// voice registers and output register. Uses psv_pkg and psv_ram.
//
// Write, note-on and note-off items are done in idle. A tick on a silent
// voice skips to the done state; a tick on a playing voice makes two reads
// through the single sample-memory port, uses the shared multiplier for the
// interpolation product and then the gain product, and loads the result
// into the output register. A result waiting in the output register does
// not block the next item; a tick only waits in its done state until the
// output register is free. The user must write gain and loop_enable through
// the configuration port while the voice is idle; the block does not check.
`default_nettype none

module pcm_sample_playback_voice (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic [1:0]                            i_func,
    input  wire logic [psv_pkg::ADDR_BITS-1:0]         i_write_address,
    input  wire logic signed [psv_pkg::SAMPLE_BITS-1:0] i_write_value,
    input  wire logic [psv_pkg::ADDR_BITS-1:0]         i_start_offset,
    input  wire logic [psv_pkg::ADDR_BITS-1:0]         i_sample_length,
    input  wire logic [psv_pkg::ADDR_BITS-1:0]         i_loop_begin,
    input  wire logic [psv_pkg::ADDR_BITS-1:0]         i_loop_finish,
    input  wire logic [psv_pkg::INC_BITS-1:0]          i_phase_increment,
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [psv_pkg::OUT_BITS-1:0]        o_sample_out,
    output logic                                       o_playing,
    input  wire logic                                  i_cfg_we,
    input  wire logic [psv_pkg::CFG_IDX_BITS-1:0]      i_cfg_index,
    input  wire logic [psv_pkg::CFG_DATA_BITS-1:0]     i_cfg_data
);

    localparam int AB  = psv_pkg::ADDR_BITS;
    localparam int SB  = psv_pkg::SAMPLE_BITS;
    localparam int FB  = psv_pkg::FRACTION_BITS;
    localparam int PB  = psv_pkg::POS_BITS;
    localparam int GB  = psv_pkg::GAIN_BITS;
    localparam int OB  = psv_pkg::OUT_BITS;
    localparam int MA  = SB + 2;
    localparam int MB  = (FB > GB ? FB : GB) + 1;
    localparam int PRB = MA + MB;
    localparam int SCB = PRB - psv_pkg::GAIN_SHIFT;

    psv_pkg::t_state r_state, n_state;

    logic          r_out_valid;
    logic          r_active;
    logic [PB-1:0] r_pos;
    logic [AB-1:0] r_start, r_length, r_loop_start, r_loop_end;
    logic [psv_pkg::INC_BITS-1:0] r_inc;
    logic [GB-1:0] r_gain;
    logic          r_loop_enable;

    logic                   r_silent, r_stop, r_has_next;
    logic [PB-1:0]          r_next_pos;
    logic [AB-1:0]          r_addr;
    logic signed [SB-1:0]   r_b;
    logic signed [MA-1:0]   r_interp;
    logic signed [PRB-1:0]  r_prod;
    logic signed [OB-1:0]   r_sample_out;
    logic                   r_playing;

    logic          in_acc, out_free;
    logic          ram_we;
    logic [AB-1:0] ram_addr;
    logic [SB-1:0] ram_rdata;
    logic [AB-1:0] idx;
    logic [FB-1:0] frac;
    logic [PB:0]   pos_sum, pos_end, pos_loop;
    logic signed [SB-1:0]  c_sel;
    logic signed [MA-1:0]  mul_a;
    logic signed [MB-1:0]  mul_b;
    logic signed [PRB-1:0] mul_p;
    logic signed [SCB-1:0] scaled;
    logic signed [OB-1:0]  sat_out;

    assign in_acc   = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign idx      = r_pos[PB-1:FB];
    assign frac     = r_pos[FB-1:0];

    psv_ram #(
        .ADDR_BITS(AB),
        .DATA_BITS(SB)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_write_value),
        .o_rdata(ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            psv_pkg::ST_IDLE: begin
                if (in_acc && i_func == psv_pkg::FUNC_TICK) begin
                    n_state = r_active ? psv_pkg::ST_READ_B : psv_pkg::ST_DONE;
                end
            end
            psv_pkg::ST_READ_B: n_state = psv_pkg::ST_READ_C;
            psv_pkg::ST_READ_C: n_state = psv_pkg::ST_INTERP;
            psv_pkg::ST_INTERP: n_state = psv_pkg::ST_SCALE;
            psv_pkg::ST_SCALE:  n_state = psv_pkg::ST_DONE;
            psv_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = psv_pkg::ST_IDLE;
                end
            end
            default: n_state = psv_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_stall  = 1'b1;
        ram_we   = 1'b0;
        ram_addr = r_addr + AB'(1);
        unique case (r_state)
            psv_pkg::ST_IDLE: begin
                o_stall  = 1'b0;
                ram_we   = i_valid && i_func == psv_pkg::FUNC_WRITE;
                ram_addr = (i_func == psv_pkg::FUNC_WRITE) ? i_write_address
                                                            : r_start + idx;
            end
            psv_pkg::ST_READ_B,
            psv_pkg::ST_READ_C,
            psv_pkg::ST_INTERP,
            psv_pkg::ST_SCALE,
            psv_pkg::ST_DONE: begin
                o_stall = 1'b1;
            end
            default: o_stall = 1'b1;
        endcase
    end

    // position arithmetic
    always_comb begin
        pos_sum  = {1'b0, r_pos} + (PB + 1)'(r_inc);
        pos_end  = {1'b0, r_length, FB'(0)};
        pos_loop = {1'b0, r_loop_end, FB'(0)};
    end

    // shared multiplier operands
    always_comb begin
        c_sel = r_has_next ? $signed(ram_rdata) : r_b;
        if (r_state == psv_pkg::ST_SCALE) begin
            mul_a = r_interp;
            mul_b = $signed({1'b0, (MB - 1)'(r_gain)});
        end else begin
            mul_a = MA'(c_sel) - MA'(r_b);
            mul_b = $signed({1'b0, (MB - 1)'(frac)});
        end
        mul_p = PRB'(mul_a) * PRB'(mul_b);
    end

    always_comb begin
        scaled = SCB'(r_prod >>> psv_pkg::GAIN_SHIFT);
        if (scaled > SCB'(2**(OB - 1) - 1)) begin
            sat_out = OB'(2**(OB - 1) - 1);
        end else if (scaled < -SCB'(2**(OB - 1))) begin
            sat_out = -OB'(2**(OB - 1));
        end else begin
            sat_out = OB'(scaled);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= psv_pkg::ST_IDLE;
            r_out_valid   <= 1'b0;
            r_active      <= 1'b0;
            r_pos         <= '0;
            r_start       <= '0;
            r_length      <= '0;
            r_loop_start  <= '0;
            r_loop_end    <= '0;
            r_inc         <= '0;
            r_gain        <= GB'(2**(GB - 1));
            r_loop_enable <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    psv_pkg::CFG_GAIN: r_gain        <= i_cfg_data[GB-1:0];
                    psv_pkg::CFG_LOOP: r_loop_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_acc && i_func == psv_pkg::FUNC_NOTE_ON) begin
                r_start      <= i_start_offset;
                r_length     <= i_sample_length;
                r_loop_start <= i_loop_begin;
                r_loop_end   <= i_loop_finish;
                r_inc        <= i_phase_increment;
                r_pos        <= '0;
                r_active     <= 1'b1;
            end
            if (in_acc && i_func == psv_pkg::FUNC_NOTE_OFF) begin
                if (r_loop_enable) begin
                    r_loop_end <= r_length;
                end else begin
                    r_pos <= {r_length, FB'(0)};
                end
            end
            if (r_state == psv_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (!r_silent) begin
                    r_pos <= r_next_pos;
                    if (r_stop) begin
                        r_active <= 1'b0;
                    end
                end
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == psv_pkg::ST_IDLE) begin
            r_addr   <= r_start + idx;
            r_silent <= !r_active;
        end
        if (r_state == psv_pkg::ST_READ_B) begin
            r_b        <= $signed(ram_rdata);
            r_has_next <= ({1'b0, idx} + (AB + 1)'(1)) < {1'b0, r_length};
            r_stop     <= pos_sum >= pos_end;
            if (pos_sum >= pos_end) begin
                r_next_pos <= pos_end[PB-1:0];
            end else if (r_loop_enable && pos_sum > pos_loop) begin
                r_next_pos <= {r_loop_start, FB'(0)};
            end else begin
                r_next_pos <= pos_sum[PB-1:0];
            end
        end
        if (r_state == psv_pkg::ST_READ_C || r_state == psv_pkg::ST_SCALE) begin
            r_prod <= mul_p;
        end
        if (r_state == psv_pkg::ST_INTERP) begin
            r_interp <= r_stop ? '0 : MA'(r_b) + MA'(r_prod >>> FB);
        end
        if (r_state == psv_pkg::ST_DONE && out_free) begin
            r_sample_out <= r_silent ? '0 : sat_out;
            r_playing    <= !r_silent && !r_stop;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_playing    = r_playing;

`ifndef SYNTHESIS
    a_tick_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_func == psv_pkg::FUNC_TICK) |=>
        (r_state == psv_pkg::ST_READ_B || r_state == psv_pkg::ST_DONE))
        else $error("tick did not start the sequencer");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psv_pkg::ST_DONE && n_state == psv_pkg::ST_IDLE) |=> r_out_valid)
        else $error("finished tick left no result");

    a_playing_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_playing) |-> r_active)
        else $error("result says playing but voice is silent");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_playing) |-> (o_sample_out == '0))
        else $error("silent result is not zero");
`endif

endmodule

`default_nettype wire

// ===== hdl/psv_ram.sv =====
// Single-port sample memory with registered read data.
// No dependencies.
`default_nettype none

module psv_ram #(
    parameter int ADDR_BITS = 16,
    parameter int DATA_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic [DATA_BITS-1:0] i_wdata,
    output logic      [DATA_BITS-1:0] o_rdata
);

    logic [DATA_BITS-1:0] r_mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
